### hw/rtl/crpg_pkg.sv
// Shared types, constants and color functions for the color RAM pixel generator.
`timescale 1ns / 1ps
package crpg_pkg;

    localparam int COLOR_DEPTH    = 2048;
    localparam int COLOR_AW       = $clog2(COLOR_DEPTH);
    localparam int SCREEN_COLUMNS = 224;

    typedef logic [1:0] req_code_t;
    localparam req_code_t REQ_WRITE = 2'd0;
    localparam req_code_t REQ_READ  = 2'd1;
    localparam req_code_t REQ_VIDEO = 2'd2;

    typedef struct packed {
        logic                rd;
        logic                wr;
        logic [COLOR_AW-1:0] addr;
        logic [7:0]          wdata;
    } mem_req_t;

    typedef struct packed {
        logic       is_video;
        logic [7:0] column;
        logic [4:0] row_group;
        logic [7:0] video_byte;
    } stage_item_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    function automatic rgb_t palette(input logic [2:0] idx);
        rgb_t c;
        case (idx)
            3'd0:    c = '{r: 8'd128, g: 8'd128, b: 8'd255};
            3'd1:    c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
            3'd2:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
            3'd3:    c = '{r: 8'd255, g: 8'd0,   b: 8'd255};
            3'd4:    c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
            3'd5:    c = '{r: 8'd255, g: 8'd255, b: 8'd0};
            3'd6:    c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
            default: c = '{r: 8'd255, g: 8'd255, b: 8'd255};
        endcase
        return c;
    endfunction

    function automatic rgb_t pixel_color(input logic [7:0] vbyte, input logic [2:0] sel,
                                         input logic [2:0] color);
        rgb_t c;
        if (vbyte[sel])
            c = palette(color);
        else
            c = '{r: 8'd0, g: 8'd0, b: 8'd255};
        return c;
    endfunction

endpackage

### hw/rtl/crpg_store.sv
// Color store: 2048 x 8 synchronous RAM with clearing sweep after reset.
`timescale 1ns / 1ps
module crpg_store
    import crpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mem_req_t    req,
    output logic [7:0]  rdata,
    output logic        busy
);

    logic [7:0]          mem [COLOR_DEPTH];
    logic [7:0]          rdata_reg;
    logic                busy_reg;
    logic                busy_next;
    logic [COLOR_AW-1:0] clr_cnt_reg;
    logic [COLOR_AW-1:0] clr_cnt_next;
    logic                we;
    logic [COLOR_AW-1:0] waddr;
    logic [7:0]          wdata;

    always_comb
    begin
        busy_next    = busy_reg;
        clr_cnt_next = clr_cnt_reg;
        if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {COLOR_AW{1'b1}})
                busy_next = 1'b0;
        end
        we    = busy_reg || req.wr;
        waddr = busy_reg ? clr_cnt_reg : req.addr;
        wdata = busy_reg ? 8'd0 : req.wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (req.rd)
            rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

    a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !(req.rd || req.wr))
        else $error("store accessed during clearing sweep");

    a_sweep_complete: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(clr_cnt_reg) == {COLOR_AW{1'b1}})
        else $error("clearing sweep ended early");

endmodule

### hw/rtl/crpg_expand.sv
// Result stage: expands a video item into eight pixels or passes a read byte.
`timescale 1ns / 1ps
module crpg_expand
    import crpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s1_valid,
    input  stage_item_t s1_item,
    input  logic [7:0]  mem_rdata,
    output logic        take,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  read_data,
    output logic [7:0]  pixel_x,
    output logic [7:0]  pixel_y,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        last
);

    logic       valid_reg, valid_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [4:0] grp_reg, grp_next;
    logic [7:0] vbyte_reg, vbyte_next;
    logic [2:0] color_reg, color_next;
    logic [7:0] rdata_reg, rdata_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    rgb_t       rgb_reg, rgb_next;
    logic       last_reg, last_next;
    logic       advance;

    assign take    = s1_valid && (!valid_reg || (result_ready && last_reg));
    assign advance = valid_reg && result_ready && !last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        grp_next   = grp_reg;
        vbyte_next = vbyte_reg;
        color_next = color_reg;
        rdata_next = rdata_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rgb_next   = rgb_reg;
        last_next  = last_reg;
        if (take)
        begin
            valid_next = 1'b1;
            cnt_next   = 3'd0;
            grp_next   = s1_item.row_group;
            vbyte_next = s1_item.video_byte;
            color_next = mem_rdata[2:0];
            if (s1_item.is_video)
            begin
                rdata_next = 8'd0;
                x_next     = s1_item.column;
                y_next     = ~{s1_item.row_group, 3'd0};
                rgb_next   = pixel_color(s1_item.video_byte, 3'd0, mem_rdata[2:0]);
                last_next  = 1'b0;
            end
            else
            begin
                rdata_next = mem_rdata;
                x_next     = 8'd0;
                y_next     = 8'd0;
                rgb_next   = '0;
                last_next  = 1'b1;
            end
        end
        else if (advance)
        begin
            cnt_next  = cnt_reg + 1'b1;
            y_next    = ~{grp_reg, cnt_next};
            rgb_next  = pixel_color(vbyte_reg, cnt_next, color_reg);
            last_next = (cnt_next == 3'd7);
        end
        else if (valid_reg && result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        grp_reg   <= grp_next;
        vbyte_reg <= vbyte_next;
        color_reg <= color_next;
        rdata_reg <= rdata_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        rgb_reg   <= rgb_next;
        last_reg  <= last_next;
    end

    assign result_valid = valid_reg;
    assign read_data    = rdata_reg;
    assign pixel_x      = x_reg;
    assign pixel_y      = y_reg;
    assign red          = rgb_reg.r;
    assign green        = rgb_reg.g;
    assign blue         = rgb_reg.b;
    assign last         = last_reg;

    a_pixel_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> valid_reg && (y_reg == $past(y_reg) - 8'd1) && (x_reg == $past(x_reg)))
        else $error("pixel run broken inside a video item");

    a_take_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        take && valid_reg |-> result_ready && last_reg)
        else $error("new item loaded over a pending result");

endmodule

### hw/rtl/color_ram_pixel_generator.sv
// Top level: request decode, address folding, color store and pixel expansion.
// Color read: staging then result register; one read per cycle while result_ready is high.
// Video item: first pixel via staging and pixel output registers, then one pixel per cycle
// while result_ready is high, eight pixels per item from the single pixel output register.
// Color write, unused request code and off-screen column give no result and enter no stage.
// Reset: asynchronous; the store's 2048 bytes are swept to zero, item_ready low meanwhile.
`timescale 1ns / 1ps
module color_ram_pixel_generator
    import crpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  req_type,
    input  logic [12:0] color_address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  column,
    input  logic [4:0]  row_group,
    input  logic [7:0]  video_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  read_data,
    output logic [7:0]  pixel_x,
    output logic [7:0]  pixel_y,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        last
);

    mem_req_t    mem_req;
    logic [7:0]  mem_rdata;
    logic        store_busy;
    logic        accept;
    logic        on_screen;
    logic        keep;
    logic        exp_take;
    logic        s1_valid_reg, s1_valid_next;
    stage_item_t s1_item_reg, s1_item_next;

    assign item_ready = !store_busy && (!s1_valid_reg || exp_take);
    assign accept     = item_valid && item_ready;
    assign on_screen  = {1'b0, column} < 9'(SCREEN_COLUMNS);

    always_comb
    begin
        mem_req       = '0;
        keep          = 1'b0;
        mem_req.wdata = write_data;
        mem_req.addr  = {color_address[12:7], color_address[4:0]};
        case (req_type)
            REQ_WRITE:
            begin
                mem_req.wr = accept;
            end
            REQ_READ:
            begin
                mem_req.rd = accept;
                keep       = accept;
            end
            REQ_VIDEO:
            begin
                mem_req.addr = {column[7:2], row_group};
                mem_req.rd   = accept && on_screen;
                keep         = accept && on_screen;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;
        if (keep)
        begin
            s1_valid_next           = 1'b1;
            s1_item_next.is_video   = (req_type == REQ_VIDEO);
            s1_item_next.column     = column;
            s1_item_next.row_group  = row_group;
            s1_item_next.video_byte = video_byte;
        end
        else if (exp_take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
    end

    crpg_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (store_busy)
    );

    crpg_expand u_expand (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid_reg),
        .s1_item      (s1_item_reg),
        .mem_rdata    (mem_rdata),
        .take         (exp_take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_data    (read_data),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last         (last)
    );

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !exp_take |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("staged item lost before hand-off");

endmodule
